// File: hw/rtl/routing_table_responder_macros.svh
// Assertion macros used by routing_table_responder.sv.
`ifndef ROUTING_TABLE_RESPONDER_MACROS_SVH
`define ROUTING_TABLE_RESPONDER_MACROS_SVH

// Checked at every clock edge outside reset.
`define RTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("routing table responder assertion failed");

// Checked at every clock edge, reset included.
`define RTR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("routing table responder assertion failed");

`endif

// File: hw/rtl/rtr_pkg.sv
// ----------------------------------------------------------------------------
// rtr_pkg
// Types and constants of the routing table responder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtr_pkg;

  localparam int unsigned NetW      = 32;
  localparam int unsigned HopInW    = 16;
  localparam int unsigned HopW      = 4;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ResultCap = 32;
  localparam int unsigned ResCntW   = 6;

  localparam logic [StatusW-1:0] ST_ENTRY    = 3'd0;
  localparam logic [StatusW-1:0] ST_ADDED    = 3'd1;
  localparam logic [StatusW-1:0] ST_DUP      = 3'd2;
  localparam logic [StatusW-1:0] ST_RESERVED = 3'd3;
  localparam logic [StatusW-1:0] ST_HOP      = 3'd4;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd5;
  localparam logic [StatusW-1:0] ST_NOMATCH  = 3'd6;

  localparam logic [CfgIdxW-1:0] CFG_LOCAL    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WILDCARD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UNKNOWN  = 2'd2;

  localparam logic [HopInW-1:0] HopFieldMax = 16'd15;

  typedef struct packed {
    logic              cmd;
    logic [NetW-1:0]   network;
    logic [HopInW-1:0] hop;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NetW-1:0]    resp_network;
    logic [HopW-1:0]    resp_hop;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [NetW-1:0] net;
    logic [HopW-1:0] hop;
  } route_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtr_ram.sv
// ----------------------------------------------------------------------------
// rtr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rtr_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/routing_table_responder.sv
// ----------------------------------------------------------------------------
// routing_table_responder
// Sorted table of network routes with add and query handling.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  rtr_pkg::in_word_t
//   out      output     out_valid_o/out_stall_i rtr_pkg::out_word_t
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// The table lives in one RAM; each entry visited is read (S_RD), then
// evaluated (S_EV). An add shifts later entries up by a read and a write
// each (S_SHRD, S_SHWR), then inserts (S_INS). Reset empties the table
// at once. A stalled output holds its word; a wildcard scan waits while it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "routing_table_responder_macros.svh"

module routing_table_responder #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_HOPS    = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire rtr_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output rtr_pkg::out_word_t               out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rtr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rtr_pkg::NetW-1:0]    cfg_data_i
);

  import rtr_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW = NetW + HopW;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_DONE, S_SHRD, S_SHWR, S_INS, S_EMIT
  } state_e;

  state_e            state_q;
  logic [NetW-1:0]   local_q, wild_reg_q, unk_reg_q;
  logic              cmd_q, wild_q;
  logic [NetW-1:0]   net_q;
  logic [HopInW-1:0] hop_q;
  logic [CW-1:0]     idx_q, pos_q, cnt_q, idx_m1;
  logic [ResCntW-1:0] nres_q;
  logic              hold_valid_q;
  route_t            hold_q;
  out_word_t         fin_q, out_q;
  logic              out_valid_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  route_t            ram_wdata, rd;
  logic [RW-1:0]     rd_raw;
  logic              out_free, scan_go, accept, hop_match, hop_bad;
  logic              out_load;
  logic [StatusW-1:0] add_st;

  assign rd        = route_t'(rd_raw);
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_m1    = idx_q - 1'b1;
  assign scan_go   = (idx_q < cnt_q) && !(wild_q && (nres_q == ResCntW'(ResultCap)));
  assign hop_match = ({{(HopInW-HopW){1'b0}}, rd.hop} < hop_q);
  assign hop_bad   = (hop_q >= HopInW'(MAX_HOPS)) || (hop_q > HopFieldMax);
  assign out_load  = out_free && (((state_q == S_EMIT)) ||
                     ((state_q == S_EV) && wild_q && hop_match && hold_valid_q));

  always_comb begin
    priority if (hold_valid_q) begin
      add_st = ST_DUP;
    end else if ((net_q == wild_reg_q) || (net_q == unk_reg_q)) begin
      add_st = ST_RESERVED;
    end else if (hop_bad) begin
      add_st = ST_HOP;
    end else if (cnt_q == CW'(TABLE_DEPTH)) begin
      add_st = ST_FULL;
    end else begin
      add_st = ST_ADDED;
    end
  end

  always_comb begin
    ram_re    = ((state_q == S_RD) && scan_go) || (state_q == S_SHRD);
    ram_raddr = (state_q == S_SHRD) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
    ram_we    = (state_q == S_SHWR) || (state_q == S_INS);
    ram_waddr = (state_q == S_SHWR) ? idx_q[AW-1:0] : pos_q[AW-1:0];
    ram_wdata = (state_q == S_SHWR) ? rd : route_t'({net_q, hop_q[HopW-1:0]});
  end

  rtr_ram #(
    .Width (RW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q    <= '0;
      wild_reg_q <= '1;
      unk_reg_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL:    local_q    <= cfg_data_i;
        CFG_WILDCARD: wild_reg_q <= cfg_data_i;
        CFG_UNKNOWN:  unk_reg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      idx_q        <= '0;
      pos_q        <= '0;
      nres_q       <= '0;
      cmd_q        <= 1'b0;
      wild_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q        <= in_word_i.cmd;
            net_q        <= in_word_i.network;
            hop_q        <= in_word_i.hop;
            idx_q        <= '0;
            pos_q        <= cnt_q;
            nres_q       <= '0;
            hold_valid_q <= 1'b0;
            wild_q       <= in_word_i.cmd && (in_word_i.network == wild_reg_q);
            if (in_word_i.cmd && (in_word_i.network != wild_reg_q)
                && (in_word_i.network == unk_reg_q)) begin
              fin_q   <= '{status: ST_ENTRY, resp_network: local_q,
                           resp_hop: '0, last: 1'b1};
              state_q <= S_EMIT;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= scan_go ? S_EV : S_DONE;
        end
        S_EV: begin
          if (wild_q) begin
            if (!(hop_match && hold_valid_q && !out_free)) begin
              if (hop_match) begin
                if (hold_valid_q) begin
                  out_q <= '{status: ST_ENTRY, resp_network: hold_q.net,
                             resp_hop: hold_q.hop, last: 1'b0};
                end
                hold_q       <= rd;
                hold_valid_q <= 1'b1;
                nres_q       <= nres_q + 1'b1;
              end
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end
          end else if (rd.net == net_q) begin
            hold_q       <= rd;
            hold_valid_q <= 1'b1;
            state_q      <= S_DONE;
          end else if (rd.net > net_q) begin
            pos_q   <= idx_q;
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (cmd_q) begin
            fin_q <= hold_valid_q
                   ? '{status: ST_ENTRY, resp_network: hold_q.net,
                       resp_hop: hold_q.hop, last: 1'b1}
                   : '{status: ST_NOMATCH, resp_network: '0,
                       resp_hop: '0, last: 1'b1};
            state_q <= S_EMIT;
          end else begin
            fin_q <= '{status: add_st, resp_network: '0, resp_hop: '0, last: 1'b1};
            priority if (add_st != ST_ADDED) begin
              state_q <= S_EMIT;
            end else if (cnt_q > pos_q) begin
              idx_q   <= cnt_q;
              state_q <= S_SHRD;
            end else begin
              state_q <= S_INS;
            end
          end
        end
        S_SHRD: begin
          state_q <= S_SHWR;
        end
        S_SHWR: begin
          idx_q   <= idx_m1;
          state_q <= (idx_m1 == pos_q) ? S_INS : S_SHRD;
        end
        S_INS: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q   <= fin_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `RTR_ASSERT(a_cnt_bound, cnt_q <= CW'(TABLE_DEPTH))
  `RTR_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1))
  `RTR_ASSERT(a_nonentry_last, (out_valid_o && (out_word_o.status != ST_ENTRY)) |-> out_word_o.last)
  `RTR_ASSERT(a_res_cap, nres_q <= ResCntW'(ResultCap))
  `RTR_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (state_q == S_IDLE))

endmodule

`default_nettype wire

// File: sim/routing_table_responder_test.sv
// ----------------------------------------------------------------------------
// routing_table_responder_test
// Drives add and query words into the routing table responder and checks
// every response word against a sorted-table predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module routing_table_responder_test;
  import rtr_pkg::*;

  localparam int unsigned Depth   = 32;
  localparam int unsigned MaxHops = 16;

  class route_scoreboard;
    logic [NetW-1:0] local_net, wild_net, unk_net;
    logic [NetW-1:0] tbl_net[Depth];
    logic [HopW-1:0] tbl_hop[Depth];
    int unsigned     count;
    out_word_t       pending_q[$];
    int unsigned     mismatches;

    function new();
      local_net = '0;
      wild_net = '1;
      unk_net = '0;
      count = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [NetW-1:0] val);
      case (idx)
        CFG_LOCAL: local_net = val;
        CFG_WILDCARD: wild_net = val;
        CFG_UNKNOWN: unk_net = val;
        default: ;
      endcase
    endfunction

    function int find_route(logic [NetW-1:0] net);
      for (int i = 0; i < count; i++) begin
        if (tbl_net[i] == net) return i;
      end
      return -1;
    endfunction

    function void push(logic [StatusW-1:0] st, logic [NetW-1:0] net,
                       logic [HopW-1:0] hp, logic fin);
      out_word_t w;
      w.status = st;
      w.resp_network = net;
      w.resp_hop = hp;
      w.last = fin;
      pending_q.push_back(w);
    endfunction

    function logic [StatusW-1:0] insert_route(logic [NetW-1:0] net,
                                              logic [HopInW-1:0] hp);
      int pos;
      if (find_route(net) >= 0) return ST_DUP;
      if (net == wild_net || net == unk_net) return ST_RESERVED;
      if (hp >= MaxHops || hp > HopFieldMax) return ST_HOP;
      if (count >= Depth) return ST_FULL;
      pos = 0;
      while (pos < count && tbl_net[pos] < net) pos++;
      for (int i = count; i > pos; i--) begin
        tbl_net[i] = tbl_net[i-1];
        tbl_hop[i] = tbl_hop[i-1];
      end
      tbl_net[pos] = net;
      tbl_hop[pos] = hp[HopW-1:0];
      count++;
      return ST_ADDED;
    endfunction

    function void note_word(in_word_t w);
      int n;
      int idx;
      if (!w.cmd) begin
        push(insert_route(w.network, w.hop), '0, '0, 1'b1);
      end else if (w.network == wild_net) begin
        n = 0;
        for (int i = 0; i < count; i++) begin
          if (n >= ResultCap) break;
          if (tbl_hop[i] < w.hop) begin
            push(ST_ENTRY, tbl_net[i], tbl_hop[i], 1'b0);
            n++;
          end
        end
        if (n == 0) push(ST_NOMATCH, '0, '0, 1'b1);
        else pending_q[$].last = 1'b1;
      end else if (w.network == unk_net) begin
        push(ST_ENTRY, local_net, '0, 1'b1);
      end else begin
        idx = find_route(w.network);
        if (idx >= 0) push(ST_ENTRY, tbl_net[idx], tbl_hop[idx], 1'b1);
        else push(ST_NOMATCH, '0, '0, 1'b1);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
        return;
      end
      exp_w = pending_q.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_w, got);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [NetW-1:0]     cfg_data_i = '0;

  route_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  logic [NetW-1:0] known_q[$];

  always #1 clk_i = ~clk_i;

  routing_table_responder #(.TABLE_DEPTH(Depth), .MAX_HOPS(MaxHops)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o,
    .out_stall_i, .out_word_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_word_o);
  end

  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic send_word(logic cmd, logic [NetW-1:0] net, logic [HopInW-1:0] hp);
    in_word_t w;
    w.cmd = cmd;
    w.network = net;
    w.hop = hp;
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    if (!cmd) known_q.push_back(net);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [NetW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [NetW-1:0] pick_net();
    case ($urandom_range(5))
      0: return sb.wild_net;
      1: return sb.unk_net;
      2, 3: return (known_q.size() != 0) ?
                   known_q[$urandom_range(known_q.size() - 1)] : $urandom;
      4: return $urandom_range(63);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HopInW-1:0] pick_hop();
    case ($urandom_range(3))
      0: return HopInW'($urandom);
      1: return HopInW'($urandom_range(17));
      default: return HopInW'($urandom_range(15));
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_word($urandom_range(99) < 55, pick_net(), pick_hop());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(1'b1, 32'h0, 16'h0);
    send_word(1'b1, 32'h5, 16'h1);
    send_word(1'b0, 32'h10, 16'd3);
    send_word(1'b0, 32'h10, 16'd2);
    send_word(1'b0, 32'hFFFF_FFFF, 16'd1);
    send_word(1'b0, 32'h0, 16'd1);
    send_word(1'b0, 32'h20, 16'd16);
    send_word(1'b0, 32'h21, 16'hFFFF);
    send_word(1'b0, 32'hFFFF_FFFE, 16'd15);
    send_word(1'b0, 32'h1, 16'd0);
    send_word(1'b0, 32'h8, 16'd7);
    send_word(1'b1, 32'hFFFF_FFFF, 16'd16);
    send_word(1'b1, 32'hFFFF_FFFF, 16'd4);
    send_word(1'b1, 32'hFFFF_FFFF, 16'd0);
    send_word(1'b1, 32'h10, 16'd0);
    send_word(1'b1, 32'h11, 16'd0);
    drain();
    write_reg(CFG_LOCAL, 32'hFFFF_FFFF);
    write_reg(CFG_WILDCARD, 32'h0);
    write_reg(CFG_UNKNOWN, 32'h0);
    send_word(1'b1, 32'h0, 16'hFFFF);
    send_word(1'b0, 32'h0, 16'd1);
    drain();
    write_reg(CFG_WILDCARD, 32'h7);
    write_reg(CFG_UNKNOWN, 32'hFFFF_FFFF);
    write_reg(CFG_LOCAL, 32'h1234_5678);
    send_word(1'b1, 32'hFFFF_FFFF, 16'd0);
    random_phase(90);
    drain();
    write_reg(CFG_WILDCARD, 32'hFFFF_FFFF);
    write_reg(CFG_UNKNOWN, 32'h0);
    write_reg(CFG_LOCAL, $urandom);
    hold_req = 1'b1;
    idle_on = 1'b0;
    for (int i = 0; i < 10; i++) send_word(1'b1, 32'hFFFF_FFFF, 16'd16);
    random_phase(80);
    idle_on = 1'b1;
    drain();
    for (int i = 0; i < 40; i++) send_word(1'b0, $urandom, HopInW'($urandom_range(15)));
    random_phase(100);
    drain();
    write_reg(CFG_UNKNOWN, $urandom_range(63));
    write_reg(CFG_WILDCARD, $urandom_range(63));
    random_phase(40);
    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
